// File: src/gwsu_pkg.sv
// ----------------------------------------------------------------------------
// gwsu_pkg
// Shared types, constants and helpers of the GIGA-WoLF strategy update unit.
// ----------------------------------------------------------------------------
package gwsu_pkg;

    // Number of actions of the player
    localparam int NUM_ACTIONS = 4;

    localparam int IDX_W  = $clog2(NUM_ACTIONS);
    localparam int CNT_W  = $clog2(NUM_ACTIONS + 1);
    localparam int PASS_W = $clog2(NUM_ACTIONS + 2);
    localparam int VAL_W  = 32;

    localparam int ONE_Q16    = 65536;
    localparam int DRAW_SCALE = 32767;
    localparam int X_BASE     = ONE_Q16 / NUM_ACTIONS;
    localparam int X_EXTRA    = ONE_Q16 - X_BASE * NUM_ACTIONS;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_ACTIONS - 1);

    // floor(m/3) = (m * RECIP3) >> 33 for any m below 2^32
    localparam logic [32:0] RECIP3 = 33'h0AAAAAAAB;

    // Request codes
    localparam logic OP_DRAW   = 1'b0;
    localparam logic OP_PAYOFF = 1'b1;

    // Result codes
    localparam logic KIND_ACTION = 1'b0;
    localparam logic KIND_PROB   = 1'b1;

    typedef struct packed {
        logic               operation;
        logic signed [15:0] payoff;
        logic               last_payoff;
        logic [14:0]        random_draw;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [3:0]  action_index;
        logic [15:0] probability;
        logic        last;
    } out_item_t;

    // Operand set of the shared divider
    typedef enum logic [1:0] {
        DIV_ETA,
        DIV_PROJ,
        DIV_DELTA
    } div_sel_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DRAW,
        S_EMIT_DRAW,
        S_WAIT_DRAW,
        S_INC,
        S_ETA_GO,
        S_ETA_DIV,
        S_ETA_SQRT,
        S_STEP_MUL,
        S_STEP_ADD,
        S_STEP_Z,
        S_PJ_SUM,
        S_PJ_INIT,
        S_PJ_GO,
        S_PJ_DIV,
        S_PJ_APPLY,
        S_PJ_END,
        S_PJ_CHK,
        S_DIST_A,
        S_DIST_B,
        S_DIST_C,
        S_DELTA_CHK,
        S_DELTA_DIV,
        S_DELTA_SQRT,
        S_FIN_MUL,
        S_FIN_ADD,
        S_EMIT_UPD,
        S_WAIT_UPD
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic     accept;
        logic     idx_clr;
        logic     idx_inc;
        logic     draw_step;
        logic     inc_round;
        logic     div_start;
        div_sel_t div_sel;
        logic     sqrt_start;
        logic     eta_load;
        logic     step_mul;
        logic     step_add;
        logic     step_z;
        logic     pj_begin_x;
        logic     pj_begin_z;
        logic     pj_sum;
        logic     pj_init;
        logic     pj_div_latch;
        logic     pj_apply;
        logic     pj_pass_end;
        logic     dist_clr;
        logic     dist_a;
        logic     dist_b;
        logic     dist_c;
        logic     delta_one;
        logic     delta_load;
        logic     fin_mul;
        logic     fin_add;
        logic     clear_load;
        logic     out_load;
        logic     out_kind;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic idx_last;
        logic draw_hit;
        logic div_done;
        logic sqrt_done;
        logic pj_stop;
        logic diff_zero;
        logic sel_z;
        logic delta_full;
        logic out_take;
    } dp_stat_t;

    // Clamp a probability into 16 bits
    function automatic logic [15:0] sat16(input logic signed [VAL_W-1:0] p);
        logic [15:0] r;
        if (p < 0)
            r = 16'd0;
        else if (p > VAL_W'(65535))
            r = 16'hFFFF;
        else
            r = p[15:0];
        return r;
    endfunction

endpackage

// File: src/giga_wolf_strategy_update_unit.sv
// ----------------------------------------------------------------------------
// giga_wolf_strategy_update_unit
// GIGA-WoLF mixed strategy update with action draw, one request at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready with an in_item_t payload; results
//   leave on out_valid/out_ready as out_item_t, held in an output register.
//   A draw request scans the cumulative strategy, one action per cycle, and
//   presents its one result once the scan ends. A payoff request is stored
//   in the payoff buffer while it has room. The payoff marked last starts
//   an update: a 33-step divide and 32-step root for the step size, a
//   multiply, add and z step per action, two simplex projections (each pass
//   is a 32-step divide plus a sweep over the actions, at most N+1 passes),
//   a distance sweep over the actions, an optional 32-step divide and 32-step
//   root for the mixing weight, and a multiply and add per action for the
//   write back. The N results follow, one per action.
//   in_ready is high only while no request is in work. A stalled receiver
//   holds the block in its emit phase. Reset restores the uniform strategy,
//   clears the round counter and the payoff fill count.
// ----------------------------------------------------------------------------
module giga_wolf_strategy_update_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  gwsu_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output gwsu_pkg::out_item_t out_data
);

    gwsu_pkg::ctrl_cmd_t cmd;
    gwsu_pkg::dp_stat_t  stat;

    gwsu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_op    (in_data.operation),
        .in_last  (in_data.last_payoff),
        .stat     (stat),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    gwsu_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .out_ready (out_ready),
        .stat      (stat),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

// File: src/gwsu_div.sv
// ----------------------------------------------------------------------------
// gwsu_div
// Restoring divider, one quotient bit per cycle, with a preloadable remainder.
// ----------------------------------------------------------------------------
module gwsu_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] rem_init,
    input  logic [63:0] dvd_init,
    input  logic [63:0] divisor,
    input  logic [5:0]  steps,
    output logic        done,
    output logic [63:0] quo,
    output logic [63:0] rem
);

    logic [63:0] rem_reg, dvd_reg, div_reg, quo_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [64:0] trial;
    logic [64:0] diff;
    logic        ge;

    // One shift-and-subtract step
    always_comb
    begin
        trial = {rem_reg, dvd_reg[63]};
        diff  = trial - {1'b0, div_reg};
        ge    = trial >= {1'b0, div_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= rem_init;
            dvd_reg <= dvd_init;
            div_reg <= divisor;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[63:0] : trial[63:0];
            dvd_reg <= {dvd_reg[62:0], 1'b0};
            quo_reg <= {quo_reg[62:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

// File: src/gwsu_sqrt.sv
// ----------------------------------------------------------------------------
// gwsu_sqrt
// Integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module gwsu_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] value,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] v_reg, r_reg, bit_reg;
    logic        busy_reg, done_reg;
    logic [63:0] trial;

    assign trial = r_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                busy_reg <= 1'b1;
            else if (busy_reg && bit_reg == 64'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Digit-by-digit root
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= value;
            r_reg   <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_reg <= v_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
                r_reg <= r_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = r_reg[31:0];

endmodule

// File: src/gwsu_dp.sv
// ----------------------------------------------------------------------------
// gwsu_dp
// Datapath: strategy state, payoff buffer, projection, distance and output.
// ----------------------------------------------------------------------------
module gwsu_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  gwsu_pkg::ctrl_cmd_t cmd,
    input  gwsu_pkg::in_item_t  in_data,
    input  logic                out_ready,
    output gwsu_pkg::dp_stat_t  stat,
    output logic                out_valid,
    output gwsu_pkg::out_item_t out_data
);

    localparam int N  = gwsu_pkg::NUM_ACTIONS;
    localparam int IW = gwsu_pkg::IDX_W;
    localparam int CW = gwsu_pkg::CNT_W;
    localparam int PW = gwsu_pkg::PASS_W;
    localparam int VW = gwsu_pkg::VAL_W;

    function automatic logic [31:0] abs32(input logic signed [31:0] a);
        logic [31:0] r;
        r = a[31] ? 32'(-a) : 32'(a);
        return r;
    endfunction

    // Strategy and round state
    logic signed [VW-1:0] x_reg  [N];
    logic signed [VW-1:0] z_reg  [N];
    logic signed [VW-1:0] nx_reg [N];
    logic signed [VW-1:0] nz_reg [N];
    logic signed [15:0]   pay_reg [N];
    logic [CW-1:0]        load_reg;
    logic [31:0]          round_reg;

    // Work registers
    logic [IW-1:0]        idx_reg;
    logic [IW-1:0]        pick_reg;
    logic [14:0]          draw_reg;
    logic signed [VW-1:0] cum_reg;
    logic [16:0]          eta_reg;
    logic [16:0]          delta_reg;
    logic signed [33:0]   prod_reg;
    logic [64:0]          z3_reg;
    logic                 z3_neg_reg;
    logic                 sel_reg;
    logic signed [VW-1:0] sum_reg, diff_reg, next_reg, q_reg;
    logic [CW-1:0]        rem_reg, cnt_reg;
    logic [PW-1:0]        pass_reg;
    logic [N-1:0]         active_reg;
    logic [63:0]          sq_reg, sz_reg, sx_reg;
    logic signed [49:0]   fprod_reg;
    logic                 out_valid_reg;
    gwsu_pkg::out_item_t  out_reg;

    // Divider and root units
    logic        div_done, sqrt_done;
    logic [63:0] div_rem_init, div_dvd_init, div_divisor, div_quo, div_rem;
    logic [5:0]  div_steps;
    logic [31:0] sqrt_root;

    // Combinational helpers
    logic signed [VW-1:0] x_sel, z_sel, nx_sel, nz_sel, pv_sel, pv_add;
    logic signed [15:0]   pay_sel;
    logic signed [VW-1:0] cum_next;
    logic signed [47:0]   cum_w;
    logic [30:0]          draw_lhs;
    logic signed [47:0]   draw_rhs;
    logic                 draw_hit;
    logic signed [17:0]   eta_s;
    logic signed [33:0]   prod_w;
    logic signed [VW-1:0] step_x;
    logic [31:0]          step_mag;
    logic [64:0]          z3_w;
    logic signed [VW-1:0] z3_q;
    logic [31:0]          dz_abs, dx_abs, diff_abs;
    logic signed [VW-1:0] dzx;
    logic signed [17:0]   delta_s;
    logic [31:0]          q_mag;
    logic [CW-1:0]        r_mag;

    // Indexed reads
    always_comb
    begin
        x_sel   = x_reg[idx_reg];
        z_sel   = z_reg[idx_reg];
        nx_sel  = nx_reg[idx_reg];
        nz_sel  = nz_reg[idx_reg];
        pay_sel = (CW'(idx_reg) < load_reg) ? pay_reg[idx_reg] : 16'sd0;
        pv_sel  = sel_reg ? nz_sel : nx_sel;
        pv_add  = pv_sel + q_reg + ((rem_reg != '0) ? VW'(1) : VW'(0));
    end

    // Draw comparison: draw*65536 < cum*32767
    always_comb
    begin
        cum_next = cum_reg + x_sel;
        cum_w    = 48'(cum_next);
        draw_lhs = {draw_reg, 16'd0};
        draw_rhs = (cum_w <<< 15) - cum_w;
        draw_hit = $signed({17'd0, draw_lhs}) < draw_rhs;
    end

    // Step arithmetic
    always_comb
    begin
        eta_s    = $signed({1'b0, eta_reg});
        prod_w   = eta_s * pay_sel;
        step_x   = VW'(prod_reg >>> 8);
        step_mag = step_x[VW-1] ? 32'(-step_x) + 32'd2 : 32'(step_x);
        z3_w     = 65'(step_mag) * 65'(gwsu_pkg::RECIP3);
        z3_q     = $signed({1'b0, z3_reg[63:33]});
        dz_abs   = abs32(nz_sel - z_sel);
        dx_abs   = abs32(nz_sel - nx_sel);
        dzx      = nz_sel - nx_sel;
        delta_s  = $signed({1'b0, delta_reg});
        diff_abs = abs32(diff_reg);
        q_mag    = div_quo[31:0];
        r_mag    = div_rem[CW-1:0];
    end

    // Divider operand selection
    always_comb
    begin
        unique case (cmd.div_sel)
            gwsu_pkg::DIV_ETA:
            begin
                div_rem_init = '0;
                div_dvd_init = 64'h8000_0000_0000_0000;
                div_divisor  = {32'd0, round_reg};
                div_steps    = 6'd33;
            end
            gwsu_pkg::DIV_PROJ:
            begin
                div_rem_init = '0;
                div_dvd_init = {diff_abs, 32'd0};
                div_divisor  = 64'(cnt_reg);
                div_steps    = 6'd32;
            end
            gwsu_pkg::DIV_DELTA:
            begin
                div_rem_init = sz_reg;
                div_dvd_init = '0;
                div_divisor  = sx_reg;
                div_steps    = 6'd32;
            end
            default:
            begin
                div_rem_init = '0;
                div_dvd_init = '0;
                div_divisor  = 64'd1;
                div_steps    = 6'd1;
            end
        endcase
    end

    gwsu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .rem_init (div_rem_init),
        .dvd_init (div_dvd_init),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .done     (div_done),
        .quo      (div_quo),
        .rem      (div_rem)
    );

    gwsu_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.sqrt_start),
        .value (div_quo),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    // Control state of the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                x_reg[i] <= VW'(gwsu_pkg::X_BASE + ((i < gwsu_pkg::X_EXTRA) ? 1 : 0));
                z_reg[i] <= VW'(gwsu_pkg::X_BASE + ((i < gwsu_pkg::X_EXTRA) ? 1 : 0));
            end
            load_reg      <= '0;
            round_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // index counter
            if (cmd.idx_clr)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + IW'(1);

            // payoff fill count
            if (cmd.clear_load)
                load_reg <= '0;
            else if (cmd.accept && in_data.operation == gwsu_pkg::OP_PAYOFF
                     && load_reg < CW'(N))
                load_reg <= load_reg + CW'(1);

            // saturating round counter
            if (cmd.inc_round && round_reg != 32'hFFFF_FFFF)
                round_reg <= round_reg + 32'd1;

            // final strategy write
            if (cmd.fin_add)
            begin
                x_reg[idx_reg] <= nx_sel + VW'(fprod_reg >>> 16);
                z_reg[idx_reg] <= nz_sel;
            end

            // output register
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload and work registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            draw_reg <= in_data.random_draw;
            cum_reg  <= '0;
            if (in_data.operation == gwsu_pkg::OP_PAYOFF && load_reg < CW'(N))
                pay_reg[load_reg[IW-1:0]] <= in_data.payoff;
        end

        if (cmd.draw_step)
        begin
            cum_reg  <= cum_next;
            pick_reg <= idx_reg;
        end

        if (cmd.eta_load)
            eta_reg <= sqrt_root[16:0];

        // learning steps
        if (cmd.step_mul)
            prod_reg <= prod_w;
        if (cmd.step_add)
        begin
            nx_reg[idx_reg] <= x_sel + step_x;
            z3_reg          <= z3_w;
            z3_neg_reg      <= step_x[VW-1];
        end
        if (cmd.step_z)
            nz_reg[idx_reg] <= z_sel + (z3_neg_reg ? -z3_q : z3_q);

        // projection
        if (cmd.pj_begin_x || cmd.pj_begin_z)
        begin
            sum_reg <= '0;
            sel_reg <= cmd.pj_begin_z;
        end
        if (cmd.pj_sum)
            sum_reg <= sum_reg + pv_sel;
        if (cmd.pj_init)
        begin
            diff_reg   <= VW'(gwsu_pkg::ONE_Q16) - sum_reg;
            pass_reg   <= '0;
            cnt_reg    <= CW'(N);
            active_reg <= '1;
        end
        if (cmd.pj_div_latch)
        begin
            next_reg <= '0;
            if (!diff_reg[VW-1])
            begin
                q_reg   <= $signed(q_mag);
                rem_reg <= r_mag;
            end
            else if (r_mag == '0)
            begin
                q_reg   <= -$signed(q_mag);
                rem_reg <= '0;
            end
            else
            begin
                q_reg   <= -$signed(q_mag) - VW'(1);
                rem_reg <= cnt_reg - r_mag;
            end
        end
        if (cmd.pj_apply && active_reg[idx_reg])
        begin
            if (rem_reg != '0)
                rem_reg <= rem_reg - CW'(1);
            if (pv_add <= 0)
            begin
                next_reg            <= next_reg + pv_add;
                active_reg[idx_reg] <= 1'b0;
                cnt_reg             <= cnt_reg - CW'(1);
                if (sel_reg)
                    nz_reg[idx_reg] <= '0;
                else
                    nx_reg[idx_reg] <= '0;
            end
            else if (sel_reg)
                nz_reg[idx_reg] <= pv_add;
            else
                nx_reg[idx_reg] <= pv_add;
        end
        if (cmd.pj_pass_end)
        begin
            diff_reg <= next_reg;
            pass_reg <= pass_reg + PW'(1);
        end

        // squared distances
        if (cmd.dist_clr)
        begin
            sz_reg <= '0;
            sx_reg <= '0;
        end
        if (cmd.dist_a)
            sq_reg <= 64'(dz_abs) * 64'(dz_abs);
        if (cmd.dist_b)
        begin
            sz_reg <= sz_reg + sq_reg;
            sq_reg <= 64'(dx_abs) * 64'(dx_abs);
        end
        if (cmd.dist_c)
            sx_reg <= sx_reg + sq_reg;

        // mixing weight
        if (cmd.delta_one)
            delta_reg <= 17'(gwsu_pkg::ONE_Q16);
        else if (cmd.delta_load)
            delta_reg <= sqrt_root[16:0];
        if (cmd.fin_mul)
            fprod_reg <= delta_s * dzx;

        // result payload
        if (cmd.out_load)
        begin
            out_reg.kind <= cmd.out_kind;
            if (cmd.out_kind == gwsu_pkg::KIND_ACTION)
            begin
                out_reg.action_index <= 4'(pick_reg);
                out_reg.probability  <= gwsu_pkg::sat16(x_reg[pick_reg]);
                out_reg.last         <= 1'b1;
            end
            else
            begin
                out_reg.action_index <= 4'(idx_reg);
                out_reg.probability  <= gwsu_pkg::sat16(x_sel);
                out_reg.last         <= (idx_reg == gwsu_pkg::IDX_LAST);
            end
        end
    end

    // Status to the controller
    always_comb
    begin
        stat.idx_last   = (idx_reg == gwsu_pkg::IDX_LAST);
        stat.draw_hit   = draw_hit;
        stat.div_done   = div_done;
        stat.sqrt_done  = sqrt_done;
        stat.pj_stop    = (cnt_reg == '0) || (pass_reg > PW'(N));
        stat.diff_zero  = (diff_reg == '0);
        stat.sel_z      = sel_reg;
        stat.delta_full = (sz_reg >= sx_reg);
        stat.out_take   = out_valid_reg && out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// File: src/gwsu_ctrl.sv
// ----------------------------------------------------------------------------
// gwsu_ctrl
// Sequencer: accepts requests and steps the datapath through draw and update.
// ----------------------------------------------------------------------------
module gwsu_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_op,
    input  logic                in_last,
    input  gwsu_pkg::dp_stat_t  stat,
    output logic                in_ready,
    output gwsu_pkg::ctrl_cmd_t cmd
);

    gwsu_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= gwsu_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gwsu_pkg::S_IDLE:
                if (in_valid)
                begin
                    if (in_op == gwsu_pkg::OP_DRAW)
                        state_next = gwsu_pkg::S_DRAW;
                    else if (in_last)
                        state_next = gwsu_pkg::S_INC;
                end
            gwsu_pkg::S_DRAW:
                if (stat.draw_hit || stat.idx_last)
                    state_next = gwsu_pkg::S_EMIT_DRAW;
            gwsu_pkg::S_EMIT_DRAW:
                state_next = gwsu_pkg::S_WAIT_DRAW;
            gwsu_pkg::S_WAIT_DRAW:
                if (stat.out_take)
                    state_next = gwsu_pkg::S_IDLE;
            gwsu_pkg::S_INC:
                state_next = gwsu_pkg::S_ETA_GO;
            gwsu_pkg::S_ETA_GO:
                state_next = gwsu_pkg::S_ETA_DIV;
            gwsu_pkg::S_ETA_DIV:
                if (stat.div_done)
                    state_next = gwsu_pkg::S_ETA_SQRT;
            gwsu_pkg::S_ETA_SQRT:
                if (stat.sqrt_done)
                    state_next = gwsu_pkg::S_STEP_MUL;
            gwsu_pkg::S_STEP_MUL:
                state_next = gwsu_pkg::S_STEP_ADD;
            gwsu_pkg::S_STEP_ADD:
                state_next = gwsu_pkg::S_STEP_Z;
            gwsu_pkg::S_STEP_Z:
                state_next = stat.idx_last ? gwsu_pkg::S_PJ_SUM : gwsu_pkg::S_STEP_MUL;
            gwsu_pkg::S_PJ_SUM:
                if (stat.idx_last)
                    state_next = gwsu_pkg::S_PJ_INIT;
            gwsu_pkg::S_PJ_INIT:
                state_next = gwsu_pkg::S_PJ_GO;
            gwsu_pkg::S_PJ_GO:
                state_next = gwsu_pkg::S_PJ_DIV;
            gwsu_pkg::S_PJ_DIV:
                if (stat.div_done)
                    state_next = gwsu_pkg::S_PJ_APPLY;
            gwsu_pkg::S_PJ_APPLY:
                if (stat.idx_last)
                    state_next = gwsu_pkg::S_PJ_END;
            gwsu_pkg::S_PJ_END:
                state_next = gwsu_pkg::S_PJ_CHK;
            gwsu_pkg::S_PJ_CHK:
                if (stat.pj_stop || stat.diff_zero)
                    state_next = stat.sel_z ? gwsu_pkg::S_DIST_A : gwsu_pkg::S_PJ_SUM;
                else
                    state_next = gwsu_pkg::S_PJ_GO;
            gwsu_pkg::S_DIST_A:
                state_next = gwsu_pkg::S_DIST_B;
            gwsu_pkg::S_DIST_B:
                state_next = gwsu_pkg::S_DIST_C;
            gwsu_pkg::S_DIST_C:
                state_next = stat.idx_last ? gwsu_pkg::S_DELTA_CHK : gwsu_pkg::S_DIST_A;
            gwsu_pkg::S_DELTA_CHK:
                state_next = stat.delta_full ? gwsu_pkg::S_FIN_MUL : gwsu_pkg::S_DELTA_DIV;
            gwsu_pkg::S_DELTA_DIV:
                if (stat.div_done)
                    state_next = gwsu_pkg::S_DELTA_SQRT;
            gwsu_pkg::S_DELTA_SQRT:
                if (stat.sqrt_done)
                    state_next = gwsu_pkg::S_FIN_MUL;
            gwsu_pkg::S_FIN_MUL:
                state_next = gwsu_pkg::S_FIN_ADD;
            gwsu_pkg::S_FIN_ADD:
                state_next = stat.idx_last ? gwsu_pkg::S_EMIT_UPD : gwsu_pkg::S_FIN_MUL;
            gwsu_pkg::S_EMIT_UPD:
                state_next = gwsu_pkg::S_WAIT_UPD;
            gwsu_pkg::S_WAIT_UPD:
                if (stat.out_take)
                    state_next = stat.idx_last ? gwsu_pkg::S_IDLE : gwsu_pkg::S_EMIT_UPD;
            default:
                state_next = gwsu_pkg::S_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd         = '0;
        cmd.div_sel = gwsu_pkg::DIV_ETA;
        in_ready    = 1'b0;
        unique case (state_reg)
            gwsu_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.accept  = in_valid;
                cmd.idx_clr = in_valid;
            end
            gwsu_pkg::S_DRAW:
            begin
                cmd.draw_step = 1'b1;
                cmd.idx_inc   = !(stat.draw_hit || stat.idx_last);
            end
            gwsu_pkg::S_EMIT_DRAW:
            begin
                cmd.out_load = 1'b1;
                cmd.out_kind = gwsu_pkg::KIND_ACTION;
            end
            gwsu_pkg::S_WAIT_DRAW: ;
            gwsu_pkg::S_INC:
                cmd.inc_round = 1'b1;
            gwsu_pkg::S_ETA_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = gwsu_pkg::DIV_ETA;
            end
            gwsu_pkg::S_ETA_DIV:
                cmd.sqrt_start = stat.div_done;
            gwsu_pkg::S_ETA_SQRT:
            begin
                cmd.eta_load = stat.sqrt_done;
                cmd.idx_clr  = stat.sqrt_done;
            end
            gwsu_pkg::S_STEP_MUL:
                cmd.step_mul = 1'b1;
            gwsu_pkg::S_STEP_ADD:
                cmd.step_add = 1'b1;
            gwsu_pkg::S_STEP_Z:
            begin
                cmd.step_z     = 1'b1;
                cmd.idx_inc    = !stat.idx_last;
                cmd.idx_clr    = stat.idx_last;
                cmd.pj_begin_x = stat.idx_last;
            end
            gwsu_pkg::S_PJ_SUM:
            begin
                cmd.pj_sum  = 1'b1;
                cmd.idx_inc = !stat.idx_last;
            end
            gwsu_pkg::S_PJ_INIT:
                cmd.pj_init = 1'b1;
            gwsu_pkg::S_PJ_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = gwsu_pkg::DIV_PROJ;
            end
            gwsu_pkg::S_PJ_DIV:
            begin
                cmd.pj_div_latch = stat.div_done;
                cmd.idx_clr      = stat.div_done;
            end
            gwsu_pkg::S_PJ_APPLY:
            begin
                cmd.pj_apply = 1'b1;
                cmd.idx_inc  = !stat.idx_last;
            end
            gwsu_pkg::S_PJ_END:
                cmd.pj_pass_end = 1'b1;
            gwsu_pkg::S_PJ_CHK:
                if (stat.pj_stop || stat.diff_zero)
                begin
                    cmd.idx_clr    = 1'b1;
                    cmd.pj_begin_z = !stat.sel_z;
                    cmd.dist_clr   = stat.sel_z;
                end
            gwsu_pkg::S_DIST_A:
                cmd.dist_a = 1'b1;
            gwsu_pkg::S_DIST_B:
                cmd.dist_b = 1'b1;
            gwsu_pkg::S_DIST_C:
            begin
                cmd.dist_c  = 1'b1;
                cmd.idx_inc = !stat.idx_last;
                cmd.idx_clr = stat.idx_last;
            end
            gwsu_pkg::S_DELTA_CHK:
            begin
                cmd.delta_one = stat.delta_full;
                cmd.div_start = !stat.delta_full;
                cmd.div_sel   = gwsu_pkg::DIV_DELTA;
            end
            gwsu_pkg::S_DELTA_DIV:
                cmd.sqrt_start = stat.div_done;
            gwsu_pkg::S_DELTA_SQRT:
                cmd.delta_load = stat.sqrt_done;
            gwsu_pkg::S_FIN_MUL:
                cmd.fin_mul = 1'b1;
            gwsu_pkg::S_FIN_ADD:
            begin
                cmd.fin_add    = 1'b1;
                cmd.idx_inc    = !stat.idx_last;
                cmd.idx_clr    = stat.idx_last;
                cmd.clear_load = stat.idx_last;
            end
            gwsu_pkg::S_EMIT_UPD:
            begin
                cmd.out_load = 1'b1;
                cmd.out_kind = gwsu_pkg::KIND_PROB;
            end
            gwsu_pkg::S_WAIT_UPD:
                cmd.idx_inc = stat.out_take && !stat.idx_last;
            default: ;
        endcase
    end

endmodule

// File: src/gwsu_checker.sv
// ----------------------------------------------------------------------------
// gwsu_checker
// Port-level checks of the strategy update unit, bound to the top level.
// ----------------------------------------------------------------------------
module gwsu_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input gwsu_pkg::in_item_t  in_data,
    input logic                out_valid,
    input logic                out_ready,
    input gwsu_pkg::out_item_t out_data
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // Nothing new is taken while a result is pending
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("request taken with a result pending");

    // A draw keeps the block busy in the next cycle
    a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.operation == gwsu_pkg::OP_DRAW |=> !in_ready)
        else $error("draw did not occupy the block");

    // A chosen action is always a single, final result
    a_draw_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == gwsu_pkg::KIND_ACTION |-> out_data.last)
        else $error("action result without last");

endmodule

bind giga_wolf_strategy_update_unit gwsu_checker u_gwsu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the strategy update unit against a cycle-free model of the update.
// A directed table covers reset, extreme payoffs, short and long rounds and
// edge draws. A random phase follows with bursty requests, receiver stalls,
// one long receiver hold-off and one drain pause.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N = gwsu_pkg::NUM_ACTIONS;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int TAIL_CYCLES = 800;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    gwsu_pkg::in_item_t  in_data;
    logic                out_valid;
    logic                out_ready;
    gwsu_pkg::out_item_t out_data;

    giga_wolf_strategy_update_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    // Model state
    longint    mix_x [N];
    longint    slow_z [N];
    longint    pay_buf [N];
    int        pay_fill;
    bit [31:0] rounds;

    gwsu_pkg::out_item_t result_q[$];
    int        error_count;
    int        cycle_count;
    bit        hold_long;

    // Directed row: request plus optional typed-in expected first result
    typedef struct {
        gwsu_pkg::in_item_t  req;
        bit                  has_exp;
        gwsu_pkg::out_item_t exp;
    } row_t;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint fdiv(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q--;
        return q;
    endfunction

    function automatic longint isqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [15:0] clamp16(longint p);
        if (p < 0)
            return 16'd0;
        return (p > 65535) ? 16'hFFFF : p[15:0];
    endfunction

    // Simplex projection by deficit spreading
    function automatic void spread_deficit(ref longint v [N]);
        bit     on [N];
        longint total, gap, q, rem, nxt;
        int     cnt;
        total = 0;
        cnt = N;
        for (int i = 0; i < N; i++)
        begin
            on[i] = 1'b1;
            total += v[i];
        end
        gap = gwsu_pkg::ONE_Q16 - total;
        for (int p = 0; p <= N && cnt > 0; p++)
        begin
            q = fdiv(gap, cnt);
            rem = gap - q * cnt;
            nxt = 0;
            for (int i = 0; i < N; i++)
            begin
                if (!on[i])
                    continue;
                v[i] += q;
                if (rem > 0)
                begin
                    v[i] += 1;
                    rem--;
                end
                if (v[i] <= 0)
                begin
                    nxt += v[i];
                    v[i] = 0;
                    on[i] = 1'b0;
                    cnt--;
                end
            end
            gap = nxt;
            if (gap == 0)
                break;
        end
    endfunction

    function automatic longint unsigned sq_gap(longint a [N], longint b [N]);
        longint unsigned s;
        longint d;
        s = 0;
        for (int i = 0; i < N; i++)
        begin
            d = a[i] - b[i];
            if (d < 0)
                d = -d;
            s += d * d;
        end
        return s;
    endfunction

    function automatic void reset_strategy();
        for (int i = 0; i < N; i++)
        begin
            mix_x[i] = gwsu_pkg::X_BASE + ((i < gwsu_pkg::X_EXTRA) ? 1 : 0);
            slow_z[i] = mix_x[i];
            pay_buf[i] = 0;
        end
        pay_fill = 0;
        rounds = 0;
    endfunction

    // One GIGA-WoLF step on the buffered payoffs
    function automatic void wolf_update();
        longint nx [N];
        longint nz [N];
        longint eta, prod;
        longint unsigned sz, sx, rem, q, delta;
        if (rounds != 32'hFFFF_FFFF)
            rounds++;
        eta = isqrt((64'd1 << 32) / rounds);
        for (int i = 0; i < N; i++)
        begin
            prod = eta * pay_buf[i];
            nx[i] = mix_x[i] + fdiv(prod, 256);
            nz[i] = slow_z[i] + fdiv(prod, 768);
        end
        spread_deficit(nx);
        spread_deficit(nz);
        sz = sq_gap(nz, slow_z);
        sx = sq_gap(nz, nx);
        if (sz >= sx)
            delta = gwsu_pkg::ONE_Q16;
        else
        begin
            rem = sz;
            q = 0;
            for (int b = 0; b < 32; b++)
            begin
                rem <<= 1;
                q <<= 1;
                if (rem >= sx)
                begin
                    rem -= sx;
                    q |= 1;
                end
            end
            delta = isqrt(q);
        end
        for (int i = 0; i < N; i++)
        begin
            mix_x[i] = nx[i] + fdiv(longint'(delta) * (nz[i] - nx[i]), gwsu_pkg::ONE_Q16);
            slow_z[i] = nz[i];
        end
    endfunction

    // Predict results of one accepted request into result_q
    function automatic void predict_request(gwsu_pkg::in_item_t r);
        gwsu_pkg::out_item_t o;
        longint    cum;
        int        pick;
        if (r.operation == gwsu_pkg::OP_DRAW)
        begin
            cum = 0;
            pick = N - 1;
            for (int i = 0; i < N; i++)
            begin
                cum += mix_x[i];
                if (longint'(r.random_draw) * gwsu_pkg::ONE_Q16 < cum * gwsu_pkg::DRAW_SCALE)
                begin
                    pick = i;
                    break;
                end
            end
            o.kind = gwsu_pkg::KIND_ACTION;
            o.action_index = 4'(pick);
            o.probability = clamp16(mix_x[pick]);
            o.last = 1'b1;
            result_q.push_back(o);
            return;
        end
        if (pay_fill < N)
        begin
            pay_buf[pay_fill] = longint'(r.payoff);
            pay_fill++;
        end
        if (!r.last_payoff)
            return;
        wolf_update();
        for (int i = 0; i < N; i++)
        begin
            o.kind = gwsu_pkg::KIND_PROB;
            o.action_index = 4'(i);
            o.probability = clamp16(mix_x[i]);
            o.last = (i == N - 1);
            result_q.push_back(o);
            pay_buf[i] = 0;
        end
        pay_fill = 0;
    endfunction

    function automatic void note_error(string what, gwsu_pkg::out_item_t e,
                                       gwsu_pkg::out_item_t a);
        error_count++;
        if (error_count <= 10)
            $display("mismatch %s: expected k=%0d i=%0d p=%0d l=%0d got k=%0d i=%0d p=%0d l=%0d",
                     what, e.kind, e.action_index, e.probability, e.last,
                     a.kind, a.action_index, a.probability, a.last);
    endfunction

    // Result checker
    always @(posedge clk)
    begin
        gwsu_pkg::out_item_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (result_q.size() == 0)
                note_error("unexpected result", out_data, out_data);
            else
            begin
                e = result_q.pop_front();
                if (e != out_data)
                    note_error("result", e, out_data);
            end
        end
    end

    // Receiver stall pattern, with a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_long)
            out_ready <= 1'b0;
        else if ((cycle_count / 300) % 3 == 0)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 3) != 0);
    end

    // Long receiver hold-off, counted here
    initial
    begin
        hold_long = 1'b0;
        wait (cycle_count == 6000);
        @(posedge clk);
        hold_long <= 1'b1;
        repeat (3000) @(posedge clk);
        hold_long <= 1'b0;
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Send one request, predicting it at acceptance
    task automatic send_request(gwsu_pkg::in_item_t r);
        in_valid <= 1'b1;
        in_data <= r;
        do
            @(posedge clk);
        while (!in_ready);
        predict_request(r);
    endtask

    task automatic idle_cycles(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    function automatic gwsu_pkg::in_item_t make_req(bit op, int pay, bit lst, int drw);
        gwsu_pkg::in_item_t r;
        r.operation = op;
        r.payoff = 16'(pay);
        r.last_payoff = lst;
        r.random_draw = 15'(drw);
        return r;
    endfunction

    function automatic row_t make_row(gwsu_pkg::in_item_t r, bit h, gwsu_pkg::out_item_t e);
        row_t w;
        w.req = r;
        w.has_exp = h;
        w.exp = e;
        return w;
    endfunction

    function automatic gwsu_pkg::out_item_t make_res(bit k, int i, int p, bit l);
        gwsu_pkg::out_item_t o;
        o.kind = k;
        o.action_index = 4'(i);
        o.probability = 16'(p);
        o.last = l;
        return o;
    endfunction

    // Random round: mostly full rounds, some short or overlong
    task automatic random_round(output int n_sent);
        int len, style;
        style = $urandom_range(0, 9);
        len = (style < 7) ? N : (style < 9 ? $urandom_range(1, N - 1)
                                           : $urandom_range(N + 1, N + 3));
        for (int i = 0; i < len; i++)
        begin
            send_request(make_req(gwsu_pkg::OP_PAYOFF,
                         ($urandom_range(0, 3) == 0) ? int'($urandom)
                                                     : int'($urandom_range(0, 1024)) - 512,
                         i == len - 1, $urandom));
            if ($urandom_range(0, 3) == 0)
                idle_cycles($urandom_range(1, 6));
        end
        n_sent = len;
    endtask

    initial
    begin
        row_t table_rows[$];
        int   sent;
        int   burst;
        int   wait_cnt;
        int   n_round;
        bit   drained;
        gwsu_pkg::out_item_t none;
        gwsu_pkg::out_item_t got;

        none = make_res(1'b0, 0, 0, 1'b0);
        drained = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        reset_strategy();
        error_count = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: draws after reset, extremes, short and overlong rounds
        table_rows.push_back(make_row(make_req(gwsu_pkg::OP_DRAW, 0, 1'b0, 0), 1'b1,
                             make_res(gwsu_pkg::KIND_ACTION, 0, gwsu_pkg::X_BASE, 1'b1)));
        table_rows.push_back(make_row(make_req(gwsu_pkg::OP_DRAW, -1, 1'b1, 32766), 1'b1,
                             make_res(gwsu_pkg::KIND_ACTION, N - 1, gwsu_pkg::X_BASE, 1'b1)));
        table_rows.push_back(make_row(make_req(gwsu_pkg::OP_DRAW, 0, 1'b0, 16383), 1'b1,
                             make_res(gwsu_pkg::KIND_ACTION, N / 2 - 1, gwsu_pkg::X_BASE,
                                      1'b1)));
        table_rows.push_back(make_row(make_req(gwsu_pkg::OP_PAYOFF, 32767, 1'b0, 32767),
                             1'b0, none));
        table_rows.push_back(make_row(make_req(gwsu_pkg::OP_PAYOFF, -32768, 1'b0, 0),
                             1'b0, none));
        table_rows.push_back(make_row(make_req(gwsu_pkg::OP_PAYOFF, 0, 1'b0, 0), 1'b0, none));
        table_rows.push_back(make_row(make_req(gwsu_pkg::OP_PAYOFF, 256, 1'b1, 0), 1'b0, none));
        table_rows.push_back(make_row(make_req(gwsu_pkg::OP_DRAW, 0, 1'b0, 0), 1'b0, none));
        table_rows.push_back(make_row(make_req(gwsu_pkg::OP_DRAW, 0, 1'b0, 32767), 1'b0, none));
        // short round
        table_rows.push_back(make_row(make_req(gwsu_pkg::OP_PAYOFF, -32768, 1'b1, 0),
                             1'b0, none));
        // overlong round
        for (int i = 0; i < N + 2; i++)
            table_rows.push_back(make_row(make_req(gwsu_pkg::OP_PAYOFF,
                                 (i % 2) ? 32767 : -32768, i == N + 1, 32767), 1'b0, none));
        table_rows.push_back(make_row(make_req(gwsu_pkg::OP_PAYOFF, 32767, 1'b1, 0),
                             1'b0, none));
        table_rows.push_back(make_row(make_req(gwsu_pkg::OP_DRAW, 0, 1'b0, 32767), 1'b0, none));

        foreach (table_rows[k])
        begin
            if (table_rows[k].has_exp)
            begin
                // typed-in value cross-checks the predictor
                if (result_q.size() != 0)
                begin
                    in_valid <= 1'b0;
                    wait (result_q.size() == 0);
                    @(posedge clk);
                end
                send_request(table_rows[k].req);
                got = (result_q.size() == 0) ? none : result_q[0];
                if (result_q.size() == 0 || got != table_rows[k].exp)
                    note_error("table", table_rows[k].exp, got);
            end
            else
                send_request(table_rows[k].req);
        end
        sent = table_rows.size();

        // Random phase
        while (sent < 260)
        begin
            burst = $urandom_range(1, 8);
            for (int b = 0; b < burst; b++)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    send_request(make_req(gwsu_pkg::OP_DRAW, $urandom, 1'($urandom),
                                          $urandom));
                    sent++;
                end
                else
                begin
                    random_round(n_round);
                    sent += n_round;
                end
            end
            if (!drained && sent > 150)
            begin
                // drain pause
                drained = 1'b1;
                in_valid <= 1'b0;
                wait (result_q.size() == 0);
                @(posedge clk);
            end
            else if ($urandom_range(0, 2) != 0)
                idle_cycles($urandom_range(1, 40));
        end
        in_valid <= 1'b0;

        wait (result_q.size() == 0);
        wait_cnt = 0;
        while (wait_cnt < TAIL_CYCLES)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        if (error_count == 0 && result_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: files.f
src/gwsu_pkg.sv
src/gwsu_div.sv
src/gwsu_sqrt.sv
src/gwsu_dp.sv
src/gwsu_ctrl.sv
src/giga_wolf_strategy_update_unit.sv
src/gwsu_checker.sv
sim/tb_top.sv
